FILE: rtl/gtb_pkg.sv
// gtb_pkg: shared types, op codes, font table and coordinate helpers
// for the glyph text block generator; no dependencies
`default_nettype none

package gtb_pkg;

  localparam int GLYPH_ROWS = 5;
  localparam int GLYPH_COLS = 3;
  localparam int GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  typedef struct packed {
    logic               op;
    logic [7:0]         char_code;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        paint;
    logic [3:0]         magnify;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] block_x;
    logic signed [15:0] block_y;
    logic [3:0]         block_side;
    logic [31:0]        block_paint;
    logic               last_block;
  } out_item_t;

  // one character's work: lit pixels in raster order, bit 0 first
  typedef struct packed {
    logic [GLYPH_BITS-1:0] mask;
    logic signed [15:0]    base_x;
    logic signed [15:0]    base_y;
    logic [3:0]            side;
    logic [31:0]           paint;
  } job_t;

  // rows top to bottom, leftmost column in the high bit of each row
  function automatic logic [GLYPH_BITS-1:0] font_rows(input logic [7:0] code);
    logic [GLYPH_BITS-1:0] g;
    g = '0;
    case (code)
      8'h30: g = 15'b111_101_101_101_111;
      8'h31: g = 15'b010_110_010_010_111;
      8'h32: g = 15'b111_001_111_100_111;
      8'h33: g = 15'b111_001_111_001_111;
      8'h34: g = 15'b101_101_111_001_001;
      8'h35: g = 15'b111_100_111_001_111;
      8'h36: g = 15'b111_100_111_101_111;
      8'h37: g = 15'b111_001_010_010_010;
      8'h38: g = 15'b111_101_111_101_111;
      8'h39: g = 15'b111_101_111_001_111;
      8'h41: g = 15'b111_101_111_101_101;
      8'h42: g = 15'b110_101_110_101_110;
      8'h43: g = 15'b111_100_100_100_111;
      8'h44: g = 15'b110_101_101_101_110;
      8'h45: g = 15'b111_100_110_100_111;
      8'h46: g = 15'b111_100_110_100_100;
      8'h47: g = 15'b111_100_101_101_111;
      8'h48: g = 15'b101_101_111_101_101;
      8'h49: g = 15'b111_010_010_010_111;
      8'h4a: g = 15'b001_001_001_101_111;
      8'h4b: g = 15'b101_101_110_101_101;
      8'h4c: g = 15'b100_100_100_100_111;
      8'h4d: g = 15'b101_111_111_101_101;
      8'h4e: g = 15'b101_111_111_111_101;
      8'h4f: g = 15'b111_101_101_101_111;
      8'h50: g = 15'b111_101_111_100_100;
      8'h51: g = 15'b111_101_101_111_001;
      8'h52: g = 15'b111_101_110_101_101;
      8'h53: g = 15'b111_100_111_001_111;
      8'h54: g = 15'b111_010_010_010_010;
      8'h55: g = 15'b101_101_101_101_111;
      8'h56: g = 15'b101_101_101_101_010;
      8'h57: g = 15'b101_101_111_111_101;
      8'h58: g = 15'b101_101_010_101_101;
      8'h59: g = 15'b101_101_010_010_010;
      8'h5a: g = 15'b111_001_010_100_111;
      8'h2f: g = 15'b001_001_010_100_100;
      8'h2d: g = 15'b000_000_111_000_000;
      8'h2e: g = 15'b000_000_000_000_010;
      8'h3a: g = 15'b000_010_000_010_000;
      8'h2b: g = 15'b000_010_111_010_000;
      8'h27: g = 15'b010_010_000_000_000;
      default: g = '0;
    endcase
    return g;
  endfunction

  // raster order mask: bit row*3+col set when that pixel is lit
  function automatic logic [GLYPH_BITS-1:0] font_mask(input logic [7:0] code);
    logic [GLYPH_BITS-1:0] g;
    logic [GLYPH_BITS-1:0] m;
    g = font_rows(code);
    for (int i = 0; i < GLYPH_BITS; i++) begin
      m[i] = g[GLYPH_BITS-1-i];
    end
    return m;
  endfunction

  // non-negative offset only, so overflow can only go positive
  function automatic logic signed [15:0] sat_add(input logic signed [15:0] base,
                                                 input logic [6:0] off);
    logic [16:0] sum;
    sum = {base[15], base} + {10'b0, off};
    if (sum[16] != sum[15]) begin
      return 16'sh7fff;
    end
    return sum[15:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gtb_front.sv
// gtb_front: string state (cursor, line, paint, scale) and font lookup;
// hands one job per lit character to the emitter; uses gtb_pkg
`default_nettype none

module gtb_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire gtb_pkg::in_item_t in_data,
  input  wire logic             emit_free,
  output logic                  load,
  output gtb_pkg::job_t         load_job
);

  logic signed [15:0] cursor_x;
  logic signed [15:0] line_y;
  logic [31:0]        held_paint;
  logic [3:0]         held_scale;
  logic               accept;
  logic [gtb_pkg::GLYPH_BITS-1:0] mask;

  assign in_ready = emit_free;
  assign accept   = in_valid && in_ready;
  assign mask     = gtb_pkg::font_mask(in_data.char_code);
  assign load     = accept && (in_data.op == gtb_pkg::OP_DRAW) && (mask != '0);

  assign load_job.mask   = mask;
  assign load_job.base_x = cursor_x;
  assign load_job.base_y = line_y;
  assign load_job.side   = held_scale;
  assign load_job.paint  = held_paint;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x   <= '0;
      line_y     <= '0;
      held_paint <= '0;
      held_scale <= 4'd1;
    end else if (accept) begin
      if (in_data.op == gtb_pkg::OP_BEGIN) begin
        cursor_x   <= in_data.pos_x;
        line_y     <= in_data.pos_y;
        held_paint <= in_data.paint;
        held_scale <= (in_data.magnify == 4'd0) ? 4'd1 : in_data.magnify;
      end else begin
        cursor_x <= gtb_pkg::sat_add(cursor_x, {1'b0, held_scale, 2'b00});
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gtb_emit.sv
// gtb_emit: job register and result register; sends one lit block per
// cycle while the output is not stalled, in raster order, and flags the last; uses gtb_pkg
`default_nettype none

module gtb_emit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire gtb_pkg::job_t  load_job,
  output logic                emit_free,
  output logic                out_valid,
  input  wire logic           out_ready,
  output gtb_pkg::out_item_t  out_data
);

  logic               work_valid;
  gtb_pkg::job_t      job;
  logic               emit;
  logic               last;
  logic [gtb_pkg::GLYPH_BITS-1:0] rest;
  logic [2:0]         sel_row;
  logic [1:0]         sel_col;
  logic [6:0]         off_x;
  logic [6:0]         off_y;
  gtb_pkg::out_item_t out_next;

  // lowest lit bit comes first
  always_comb begin
    sel_row = '0;
    sel_col = '0;
    for (int r = gtb_pkg::GLYPH_ROWS - 1; r >= 0; r--) begin
      for (int c = gtb_pkg::GLYPH_COLS - 1; c >= 0; c--) begin
        if (job.mask[r*gtb_pkg::GLYPH_COLS + c]) begin
          sel_row = 3'(r);
          sel_col = 2'(c);
        end
      end
    end
  end

  assign rest      = job.mask & (job.mask - 1'b1);
  assign last      = (rest == '0);
  assign emit      = work_valid && (!out_valid || out_ready);
  assign emit_free = !work_valid || (emit && last);

  assign off_x = {5'b0, sel_col} * {3'b0, job.side};
  assign off_y = {4'b0, sel_row} * {3'b0, job.side};

  assign out_next.block_x     = gtb_pkg::sat_add(job.base_x, off_x);
  assign out_next.block_y     = gtb_pkg::sat_add(job.base_y, off_y);
  assign out_next.block_side  = job.side;
  assign out_next.block_paint = job.paint;
  assign out_next.last_block  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (load) begin
      work_valid <= 1'b1;
    end else if (emit && last) begin
      work_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= load_job;
    end else if (emit) begin
      job.mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= out_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/glyph_text_block_generator_top.sv
// path: the first block of a character is held in the job register, then in the block output register
// throughput: one block per cycle while out_ready holds; a character sends one block per lit pixel,
// a begin, space or unknown character sends none; the output is a single block register
// reset (rst, synchronous): cursor and line at 0, paint 0, scale 1, no work pending
// top level: glyph text block generator; instantiates gtb_front and gtb_emit
// depends on gtb_pkg
`default_nettype none

module glyph_text_block_generator_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire gtb_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output gtb_pkg::out_item_t      out_data
);

  logic          emit_free;
  logic          load;
  gtb_pkg::job_t load_job;

  gtb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .emit_free (emit_free),
    .load      (load),
    .load_job  (load_job)
  );

  gtb_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_job  (load_job),
    .emit_free (emit_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/gtb_checker.sv
// gtb_checker: port-level assertions for the glyph text block generator,
// bound to the top level; depends on gtb_pkg
`default_nettype none

module gtb_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire gtb_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire gtb_pkg::out_item_t out_data
);

  // offered input transaction holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input transaction changed while waiting");

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  a_side_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.block_side != 4'd0)
    else $error("block side is zero");

  // blocks of one character follow without a gap and share side and paint
  a_char_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_block |=>
      out_valid && out_data.block_side == $past(out_data.block_side) &&
      out_data.block_paint == $past(out_data.block_paint))
    else $error("character blocks broken up");

  // no new input while a character still has blocks behind a stalled one
  a_busy_no_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !out_data.last_block |-> !in_ready)
    else $error("input taken while character unfinished");

endmodule

bind glyph_text_block_generator_top gtb_checker u_gtb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
